[hw/rtl/flvavc_pkg.sv]
// flvavc_pkg: shared types and constants for the flv avc annex b demux
// no dependencies
package flvavc_pkg;

    localparam int PSET_MAX_BYTES = 256;
    localparam int PSET_AW        = $clog2(PSET_MAX_BYTES);
    localparam int PSET_LW        = PSET_AW + 1;
    localparam int PTS_W          = 43;
    localparam int MAX_RES        = 5;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_SKIP   = 4'd1,
        PH_PREV   = 4'd2,
        PH_TAGHDR = 4'd3,
        PH_IGNORE = 4'd4,
        PH_VHDR   = 4'd5,
        PH_PREFIX = 4'd6,
        PH_BODY   = 4'd7,
        PH_SEQ    = 4'd8,
        PH_DRAIN  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        SQ_CFG     = 3'd0,
        SQ_LEN_HI  = 3'd1,
        SQ_LEN_LO  = 3'd2,
        SQ_DATA    = 3'd3,
        SQ_PPS_CNT = 3'd4,
        SQ_DONE    = 3'd5
    } seq_step_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [PTS_W-1:0] pts_us;
        logic             first;
        logic             last;
        logic             taken;
    } rslt_t;

endpackage

[hw/rtl/flvavc_ram.sv]
// flvavc_ram: single write port ram with registered read
// generic, no package dependency
module flvavc_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/flvavc_parse.sv]
// flvavc_parse: flv tag parser, nal length to start code conversion, parameter set stores
// depends on flvavc_pkg and flvavc_ram
module flvavc_parse (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    output logic [2:0]             res_n,
    output flvavc_pkg::rslt_t      res [flvavc_pkg::MAX_RES]
);
    import flvavc_pkg::*;

    phase_t            phase_reg, phase_next;
    seq_step_t         step_reg, step_next;
    logic [7:0]        win_reg [9];
    logic [7:0]        win_next [9];
    logic [31:0]       pbc_reg, pbc_next;
    logic [7:0]        kind_reg, kind_next;
    logic [23:0]       tlen_reg, tlen_next;
    logic [41:0]       ttime_reg, ttime_next;
    logic [23:0]       comp_reg, comp_next;
    logic [2:0]        prefix_reg, prefix_next;
    logic [23:0]       urem_reg, urem_next;
    logic [PSET_LW-1:0] sps_len_reg, sps_len_next, pps_len_reg, pps_len_next;
    logic [7:0]        sets_reg, sets_next;
    logic [9:0]        drain_reg, drain_next;
    logic [23:0]       tleft_reg, tleft_next;
    logic [31:0]       ts_reg, ts_next;
    logic [PTS_W-1:0]  upts_reg, upts_next;
    logic [7:0]        ptype_reg, ptype_next;
    logic              inpps_reg, inpps_next;
    logic [31:0]       lacc_reg, lacc_next;
    logic [PSET_LW-1:0] slen_reg, slen_next;

    logic              sps_we, pps_we;
    logic [PSET_AW-1:0] st_waddr, sps_raddr, pps_raddr;
    logic [7:0]        sps_rd, pps_rd;
    logic [9:0]        a_next;

    flvavc_ram #(.AW(PSET_AW), .DW(8)) u_sps (
        .aclk(aclk), .we(sps_we), .waddr(st_waddr), .wdata(in_byte),
        .raddr(sps_raddr), .rdata(sps_rd)
    );
    flvavc_ram #(.AW(PSET_AW), .DW(8)) u_pps (
        .aclk(aclk), .we(pps_we), .waddr(st_waddr), .wdata(in_byte),
        .raddr(pps_raddr), .rdata(pps_rd)
    );

    always_comb begin
        logic [23:0]       tl;
        logic [3:0]        hidx;
        logic [31:0]       cnt, hs, la;
        logic [23:0]       cnew;
        logic signed [34:0] off_us;
        logic [15:0]       sl;
        logic [9:0]        a, b, d, e, ln;
        logic [7:0]        v;
        logic              loop;

        phase_next = phase_reg; step_next = step_reg; win_next = win_reg;
        pbc_next = pbc_reg; kind_next = kind_reg; tlen_next = tlen_reg;
        ttime_next = ttime_reg; comp_next = comp_reg; prefix_next = prefix_reg;
        urem_next = urem_reg; sps_len_next = sps_len_reg; pps_len_next = pps_len_reg;
        sets_next = sets_reg; drain_next = drain_reg; tleft_next = tleft_reg;
        ts_next = ts_reg; upts_next = upts_reg; ptype_next = ptype_reg;
        inpps_next = inpps_reg; lacc_next = lacc_reg; slen_next = slen_reg;
        res_n = 3'd0;
        for (int k = 0; k < MAX_RES; k++) res[k] = '0;
        sps_we = 1'b0; pps_we = 1'b0;
        st_waddr = pbc_reg[PSET_AW-1:0];
        tl = (tleft_reg != 24'd0) ? tleft_reg - 24'd1 : tleft_reg;
        hidx = (pbc_reg > 32'd8) ? 4'd0 : pbc_reg[3:0];
        cnt = pbc_reg + 32'd1;
        hs = '0; la = '0; cnew = '0; off_us = '0; sl = '0; loop = 1'b0;
        a = (sps_len_reg != '0) ? 10'(sps_len_reg) + 10'd4 : 10'd0;
        b = (pps_len_reg != '0) ? 10'(pps_len_reg) + 10'd4 : 10'd0;
        d = drain_reg;
        e = (d < a) ? d : d - a;
        ln = (d < a) ? a : b;
        v = (e < 10'd4) ? ((e == 10'd3) ? 8'd1 : 8'd0) : ((d < a) ? sps_rd : pps_rd);

        if (in_valid) begin
            case (phase_reg)
                PH_DRAIN: begin
                    res[0] = '{out_byte: v, pts_us: '0, first: (e == 10'd0),
                               last: (e + 10'd1 == ln), taken: 1'b0};
                    res_n = 3'd1;
                    drain_next = d + 10'd1;
                    if (drain_next >= a + b) begin
                        drain_next = '0;
                        phase_next = PH_PREV;
                        pbc_next = '0;
                    end
                end
                PH_HEADER: begin
                    for (int k = 0; k < 9; k++) begin
                        if (hidx == 4'(k)) win_next[k] = in_byte;
                    end
                    pbc_next = 32'(hidx) + 32'd1;
                    if (pbc_next == 32'd9) begin
                        if (win_next[0] == 8'h46 && win_next[1] == 8'h4C &&
                            win_next[2] == 8'h56) begin
                            hs = {win_next[5], win_next[6], win_next[7], win_next[8]};
                            if (hs > 32'd9) begin
                                pbc_next = hs - 32'd9;
                                phase_next = PH_SKIP;
                            end else begin
                                pbc_next = '0;
                                phase_next = PH_PREV;
                            end
                        end else begin
                            for (int k = 0; k < 5; k++) win_next[k] = win_next[k+4];
                            pbc_next = 32'd5;
                        end
                    end
                end
                PH_SKIP: begin
                    if (pbc_reg <= 32'd1) begin
                        pbc_next = '0;
                        phase_next = PH_PREV;
                    end else begin
                        pbc_next = pbc_reg - 32'd1;
                    end
                end
                PH_PREV: begin
                    pbc_next = cnt;
                    if (cnt >= 32'd4) begin
                        pbc_next = '0;
                        phase_next = PH_TAGHDR;
                    end
                end
                PH_TAGHDR: begin
                    if (pbc_reg == 32'd0) kind_next = in_byte;
                    else if (pbc_reg == 32'd1) tlen_next = {16'd0, in_byte};
                    else if (pbc_reg <= 32'd3) tlen_next = {tlen_reg[15:0], in_byte};
                    else if (pbc_reg == 32'd4) ts_next = {24'd0, in_byte};
                    else if (pbc_reg <= 32'd6) ts_next = {ts_reg[23:0], in_byte};
                    else if (pbc_reg == 32'd7) ts_next = {in_byte, ts_reg[23:0]};
                    pbc_next = cnt;
                    if (cnt >= 32'd11) begin
                        ttime_next = 42'(ts_reg) * 42'd1000;
                        tleft_next = tlen_reg;
                        pbc_next = '0;
                        if (tlen_reg == 24'd0) phase_next = PH_PREV;
                        else if (kind_reg == 8'd9 && tlen_reg >= 24'd5) phase_next = PH_VHDR;
                        else phase_next = PH_IGNORE;
                    end
                end
                default: begin
                    tleft_next = tl;
                    case (phase_reg)
                        PH_VHDR: begin
                            pbc_next = cnt;
                            if (pbc_reg == 32'd0) begin
                                if (in_byte[3:0] != 4'd7) begin
                                    phase_next = (tl == 24'd0) ? PH_PREV : PH_IGNORE;
                                    pbc_next = '0;
                                end
                            end else if (pbc_reg == 32'd1) begin
                                ptype_next = in_byte;
                            end else if (pbc_reg == 32'd2) begin
                                comp_next = {16'd0, in_byte};
                            end else begin
                                cnew = {comp_reg[15:0], in_byte};
                                comp_next = cnew;
                                if (pbc_reg >= 32'd4) begin
                                    off_us = 35'($signed(cnew)) * 35'sd1000;
                                    upts_next = {1'b0, ttime_reg} + PTS_W'(off_us);
                                    if (ptype_reg == 8'd0 && tl >= 24'd7) begin
                                        phase_next = PH_SEQ;
                                        step_next = SQ_CFG;
                                        pbc_next = '0;
                                        sps_len_next = '0;
                                        pps_len_next = '0;
                                        inpps_next = 1'b0;
                                    end else if (ptype_reg == 8'd1 &&
                                                 tl >= 24'(prefix_reg)) begin
                                        phase_next = PH_PREFIX;
                                        pbc_next = '0;
                                        lacc_next = '0;
                                    end else begin
                                        phase_next = (tl == 24'd0) ? PH_PREV : PH_IGNORE;
                                        pbc_next = '0;
                                    end
                                end
                            end
                        end
                        PH_PREFIX: begin
                            la = {lacc_reg[23:0], in_byte};
                            lacc_next = la;
                            pbc_next = cnt;
                            if (cnt >= 32'(prefix_reg)) begin
                                if (la == 32'd0 || la > 32'(tl)) begin
                                    phase_next = (tl == 24'd0) ? PH_PREV : PH_IGNORE;
                                    pbc_next = '0;
                                end else begin
                                    urem_next = la[23:0];
                                    phase_next = PH_BODY;
                                    pbc_next = '0;
                                end
                            end
                        end
                        PH_BODY: begin
                            if (pbc_reg == 32'd0) begin
                                res[0] = '{out_byte: 8'd0, pts_us: upts_reg, first: 1'b1,
                                           last: 1'b0, taken: 1'b1};
                                res[1] = '{out_byte: 8'd0, pts_us: upts_reg, first: 1'b0,
                                           last: 1'b0, taken: 1'b1};
                                res[2] = res[1];
                                res[3] = '{out_byte: 8'd1, pts_us: upts_reg, first: 1'b0,
                                           last: 1'b0, taken: 1'b1};
                                res_n = 3'd4;
                                pbc_next = 32'd1;
                            end
                            if (urem_reg != 24'd0) urem_next = urem_reg - 24'd1;
                            res[res_n] = '{out_byte: in_byte, pts_us: upts_reg, first: 1'b0,
                                           last: (urem_next == 24'd0), taken: 1'b1};
                            res_n = res_n + 3'd1;
                            if (urem_next == 24'd0) begin
                                if (tl < 24'(prefix_reg)) begin
                                    phase_next = (tl == 24'd0) ? PH_PREV : PH_IGNORE;
                                    pbc_next = '0;
                                end else begin
                                    phase_next = PH_PREFIX;
                                    pbc_next = '0;
                                    lacc_next = '0;
                                end
                            end
                        end
                        PH_SEQ: begin
                            case (step_reg)
                                SQ_CFG: begin
                                    pbc_next = cnt;
                                    if (pbc_reg == 32'd4) begin
                                        prefix_next = {1'b0, in_byte[1:0]} + 3'd1;
                                    end else if (pbc_reg == 32'd5) begin
                                        sets_next = {3'd0, in_byte[4:0]};
                                        inpps_next = 1'b0;
                                        loop = 1'b1;
                                    end
                                end
                                SQ_LEN_HI: begin
                                    lacc_next = {24'd0, in_byte};
                                    step_next = SQ_LEN_LO;
                                end
                                SQ_LEN_LO: begin
                                    sl = {lacc_reg[7:0], in_byte};
                                    if (24'(sl) > tl || sl > 16'(PSET_MAX_BYTES)) begin
                                        phase_next = (tl == 24'd0) ? PH_PREV : PH_IGNORE;
                                        pbc_next = '0;
                                    end else begin
                                        slen_next = sl[PSET_LW-1:0];
                                        if (inpps_reg) pps_len_next = sl[PSET_LW-1:0];
                                        else sps_len_next = sl[PSET_LW-1:0];
                                        sets_next = sets_reg - 8'd1;
                                        pbc_next = '0;
                                        if (sl == 16'd0) loop = 1'b1;
                                        else step_next = SQ_DATA;
                                    end
                                end
                                SQ_DATA: begin
                                    sps_we = !inpps_reg;
                                    pps_we = inpps_reg;
                                    pbc_next = cnt;
                                    if (cnt >= 32'(slen_reg)) loop = 1'b1;
                                end
                                SQ_PPS_CNT: begin
                                    sets_next = in_byte;
                                    inpps_next = 1'b1;
                                    loop = 1'b1;
                                end
                                default: ;
                            endcase
                            if (loop) begin
                                if (sets_next != 8'd0 && tl >= 24'd2) begin
                                    step_next = SQ_LEN_HI;
                                end else if (!inpps_next) begin
                                    if (tl == 24'd0) begin
                                        phase_next = PH_PREV;
                                        pbc_next = '0;
                                    end else begin
                                        step_next = SQ_PPS_CNT;
                                    end
                                end else begin
                                    step_next = SQ_DONE;
                                end
                            end
                            if (phase_next == PH_SEQ && tl == 24'd0) begin
                                pbc_next = '0;
                                drain_next = '0;
                                phase_next = (sps_len_next != '0 || pps_len_next != '0) ?
                                             PH_DRAIN : PH_PREV;
                            end
                        end
                        default: begin
                            if (tl == 24'd0) begin
                                phase_next = PH_PREV;
                                pbc_next = '0;
                            end else begin
                                phase_next = PH_IGNORE;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // prefetch the store bytes for the next drain beat
    assign a_next = (sps_len_next != '0) ? 10'(sps_len_next) + 10'd4 : 10'd0;
    assign sps_raddr = PSET_AW'(drain_next - 10'd4);
    assign pps_raddr = PSET_AW'(drain_next - a_next - 10'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; step_reg <= SQ_CFG;
            for (int k = 0; k < 9; k++) win_reg[k] <= '0;
            pbc_reg <= '0; kind_reg <= '0; tlen_reg <= '0; ttime_reg <= '0;
            comp_reg <= '0; prefix_reg <= 3'd4; urem_reg <= '0;
            sps_len_reg <= '0; pps_len_reg <= '0; sets_reg <= '0; drain_reg <= '0;
            tleft_reg <= '0; ts_reg <= '0; upts_reg <= '0; ptype_reg <= '0;
            inpps_reg <= 1'b0; lacc_reg <= '0; slen_reg <= '0;
        end else begin
            phase_reg <= phase_next; step_reg <= step_next; win_reg <= win_next;
            pbc_reg <= pbc_next; kind_reg <= kind_next; tlen_reg <= tlen_next;
            ttime_reg <= ttime_next; comp_reg <= comp_next; prefix_reg <= prefix_next;
            urem_reg <= urem_next; sps_len_reg <= sps_len_next;
            pps_len_reg <= pps_len_next; sets_reg <= sets_next; drain_reg <= drain_next;
            tleft_reg <= tleft_next; ts_reg <= ts_next; upts_reg <= upts_next;
            ptype_reg <= ptype_next; inpps_reg <= inpps_next; lacc_reg <= lacc_next;
            slen_reg <= slen_next;
        end
    end

`ifndef ASSERT_OFF
    a_drain_has_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DRAIN |-> (sps_len_reg != '0 || pps_len_reg != '0))
        else $error("drain with no kept sets");
    a_prefix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        prefix_reg != 3'd0 && prefix_reg <= 3'd4)
        else $error("bad length prefix size");
    a_five_only_body: assert property (@(posedge aclk) disable iff (!aresetn)
        res_n == 3'd5 |-> phase_reg == PH_BODY && pbc_reg == 32'd0)
        else $error("start code outside unit start");
`endif
endmodule

[hw/rtl/flvavc_fifo.sv]
// flvavc_fifo: result queue, takes up to five results per cycle, gives one per beat
// depends on flvavc_pkg
module flvavc_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [2:0]             wr_n,
    input  flvavc_pkg::rslt_t      wr_data [flvavc_pkg::MAX_RES],
    output logic                   room,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output flvavc_pkg::rslt_t      rd_data
);
    import flvavc_pkg::*;

    rslt_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               pop;

    assign room     = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign count_next = count_reg + (FIFO_AW+1)'(wr_n) - (FIFO_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < wr_n) mem_reg[wr_ptr_reg + FIFO_AW'(k)] <= wr_data[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(wr_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");
    a_write_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_n != 3'd0 |-> room)
        else $error("results written without room");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_next))
        else $error("queue count mismatch");
`endif
endmodule

[hw/rtl/flv_avc_annexb_demux.sv]
// flv_avc_annexb_demux: flv byte stream in, annex b avc bytes with timestamps out
// depends on flvavc_pkg, flvavc_parse, flvavc_fifo
//
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_in_byte
// m_        out  m_valid/m_ready    m_out_byte m_pts_us m_first_of_unit m_last_of_unit
//                                   m_byte_taken
//
// one input beat per cycle while s_ready is high; the first byte of a nal unit gives five
// output beats, so input then waits on the output side
// s_ready follows the fill of an 8-entry result queue: high while at most 3 are held
// reset: synchronous aresetn, parser returns to header search, queue empties
// beats refused during parameter set drain come out with m_byte_taken low
module flv_avc_annexb_demux (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_in_byte,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [7:0]                              m_out_byte,
    output logic signed [flvavc_pkg::PTS_W-1:0]     m_pts_us,
    output logic                                    m_first_of_unit,
    output logic                                    m_last_of_unit,
    output logic                                    m_byte_taken
);
    import flvavc_pkg::*;

    logic [2:0] res_n;
    rslt_t      res [MAX_RES];
    rslt_t      rd_data;

    flvavc_parse u_parse (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid && s_ready), .in_byte(s_in_byte),
        .res_n(res_n), .res(res)
    );

    flvavc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_n(res_n), .wr_data(res), .room(s_ready),
        .rd_valid(m_valid), .rd_ready(m_ready), .rd_data(rd_data)
    );

    assign m_out_byte      = rd_data.out_byte;
    assign m_pts_us        = $signed(rd_data.pts_us);
    assign m_first_of_unit = rd_data.first;
    assign m_last_of_unit  = rd_data.last;
    assign m_byte_taken    = rd_data.taken;
endmodule
